// ----- hdl/ddsclp_pkg.sv -----
// Shared types, codes and keyword tables of the DDS command line parser.
`default_nettype none
package ddsclp_pkg;

  // line status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_QUERY  = 2'd1;
  localparam logic [1:0] ST_FORMAT = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  // scan phases
  localparam logic [2:0] PH_BETWEEN    = 3'd0;
  localparam logic [2:0] PH_KEY        = 3'd1;
  localparam logic [2:0] PH_VAL_EMPTY  = 3'd2;
  localparam logic [2:0] PH_VAL_DIGITS = 3'd3;
  localparam logic [2:0] PH_SKIP       = 3'd4;

  // field codes
  localparam logic [2:0] FLD_NONE   = 3'd0;
  localparam logic [2:0] FLD_FREQ   = 3'd1;
  localparam logic [2:0] FLD_AMP    = 3'd2;
  localparam logic [2:0] FLD_PHASE  = 3'd3;
  localparam logic [2:0] FLD_PREFIX = 3'd4;

  // config register indexes
  localparam logic [1:0] REG_FREQ_LIMIT  = 2'd0;
  localparam logic [1:0] REG_AMP_LIMIT   = 2'd1;
  localparam logic [1:0] REG_PHASE_LIMIT = 2'd2;

  localparam logic [28:0] FREQ_LIMIT_RST  = 29'd420000000;
  localparam logic [15:0] AMP_LIMIT_RST   = 16'd16383;
  localparam logic [15:0] PHASE_LIMIT_RST = 16'd360;

  localparam int KW_COUNT = 13;

  // keywords, first char in the top byte, zero padded
  localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
    {"F", 64'd0}, {"FREQ", 40'd0}, "FREQUENCY",
    {"A", 64'd0}, {"AMP", 48'd0}, "AMPLITUDE",
    {"P", 64'd0}, {"PH", 56'd0}, {"PHA", 48'd0}, {"PHASE", 32'd0},
    {"DDS", 48'd0}, {"SINGLE", 24'd0}, {"S", 64'd0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd1, 4'd4, 4'd9, 4'd1, 4'd3, 4'd9, 4'd1, 4'd2, 4'd3, 4'd5, 4'd3, 4'd6, 4'd1
  };
  localparam logic [2:0] KW_CODE [KW_COUNT] = '{
    FLD_FREQ, FLD_FREQ, FLD_FREQ, FLD_AMP, FLD_AMP, FLD_AMP,
    FLD_PHASE, FLD_PHASE, FLD_PHASE, FLD_PHASE,
    FLD_PREFIX, FLD_PREFIX, FLD_PREFIX
  };

  localparam logic [31:0] Q_DDS    = "DDS?";
  localparam logic [55:0] Q_SINGLE = "SINGLE?";

  // one classified byte, front to back
  typedef struct packed {
    logic [7:0] upper;
    logic [3:0] digit;
    logic       is_eol;
    logic       is_nul;
    logic       is_sep;
    logic       is_blank;
    logic       is_eq;
    logic       is_digit;
  } byte_cls_t;

endpackage
`default_nettype wire

// ----- hdl/ddsclp_front.sv -----
// Front end: takes received bytes and classifies them for the parser.
`default_nettype none
module ddsclp_front (
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      push,
  output ddsclp_pkg::byte_cls_t     push_cls,
  input  wire logic                 q_ready
);

  always_comb begin
    push_cls.upper    = (in_rx_byte >= 8'h61 && in_rx_byte <= 8'h7A) ?
                        in_rx_byte - 8'd32 : in_rx_byte;
    push_cls.digit    = in_rx_byte[3:0];
    push_cls.is_eol   = in_rx_byte == 8'h0D || in_rx_byte == 8'h0A;
    push_cls.is_nul   = in_rx_byte == 8'h00;
    push_cls.is_blank = in_rx_byte == 8'h20 || in_rx_byte == 8'h09;
    push_cls.is_sep   = push_cls.is_blank || in_rx_byte == 8'h2C;
    push_cls.is_eq    = in_rx_byte == 8'h3D;
    push_cls.is_digit = in_rx_byte >= 8'h30 && in_rx_byte <= 8'h39;
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

endmodule
`default_nettype wire

// ----- hdl/ddsclp_queue.sv -----
// Two-entry queue of classified bytes between front and back.
`default_nettype none
module ddsclp_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire ddsclp_pkg::byte_cls_t push_cls,
  output logic                       q_ready,
  output logic                       q_valid,
  output ddsclp_pkg::byte_cls_t      q_cls,
  input  wire logic                  pop
);

  ddsclp_pkg::byte_cls_t ent_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_ready = cnt_r != 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_cls   = ent_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_cls;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ddsclp_back.sv -----
// Back end: line scanner, token parser and result register.
`default_nettype none
module ddsclp_back #(
  parameter int LINE_CHARS = 80
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire ddsclp_pkg::byte_cls_t q_cls,
  output logic                       pop,
  input  wire logic [28:0]           freq_limit,
  input  wire logic [15:0]           amp_limit,
  input  wire logic [15:0]           phase_limit,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_line_status,
  output logic [28:0]                out_frequency_hz,
  output logic [15:0]                out_amplitude_word,
  output logic [15:0]                out_phase_degrees,
  output logic [2:0]                 out_fields_given
);

  localparam int LEN_W = $clog2(LINE_CHARS);
  localparam int KN    = ddsclp_pkg::KW_COUNT;

  typedef struct packed {
    logic [2:0]    ph;
    logic          first;
    logic [KN-1:0] kflags;
    logic [3:0]    kpos;
    logic [1:0]    qflags;
    logic [2:0]    qpos;
    logic [28:0]   acc;
    logic [2:0]    fld;
    logic [1:0]    err;
    logic          ended;
    logic [28:0]   fs;
    logic [15:0]   as;
    logic [15:0]   ps;
    logic [2:0]    ff;
  } scan_t;

  function automatic scan_t line_init();
    scan_t s;
    s        = '0;
    s.ph     = ddsclp_pkg::PH_BETWEEN;
    s.first  = 1'b1;
    s.kflags = '1;
    s.qflags = 2'b11;
    s.fld    = ddsclp_pkg::FLD_NONE;
    return s;
  endfunction

  function automatic logic [2:0] key_code(scan_t s);
    logic [2:0] code;
    code = ddsclp_pkg::FLD_NONE;
    for (int i = KN - 1; i >= 0; i--) begin
      if (s.kflags[i] && ddsclp_pkg::KW_LEN[i] == s.kpos) begin
        code = ddsclp_pkg::KW_CODE[i];
      end
    end
    return code;
  endfunction

  function automatic scan_t set_error(scan_t s, logic [1:0] code);
    scan_t r;
    r = s;
    if (r.err == ddsclp_pkg::ST_OK) begin
      r.err = code;
    end
    r.ph = ddsclp_pkg::PH_SKIP;
    return r;
  endfunction

  function automatic scan_t end_token(scan_t s, logic at_end);
    scan_t r;
    r = s;
    if (s.ph == ddsclp_pkg::PH_KEY) begin
      if (!at_end && s.first && key_code(s) == ddsclp_pkg::FLD_PREFIX) begin
        r.first = 1'b0;
        r.ph    = ddsclp_pkg::PH_BETWEEN;
      end else begin
        r = set_error(s, ddsclp_pkg::ST_FORMAT);
      end
    end else if (s.ph == ddsclp_pkg::PH_VAL_EMPTY) begin
      r = set_error(s, ddsclp_pkg::ST_FORMAT);
    end else if (s.ph == ddsclp_pkg::PH_VAL_DIGITS) begin
      if (s.fld == ddsclp_pkg::FLD_FREQ) begin
        r.fs    = s.acc;
        r.ff[0] = 1'b1;
      end else if (s.fld == ddsclp_pkg::FLD_AMP) begin
        r.as    = s.acc[15:0];
        r.ff[1] = 1'b1;
      end else if (s.fld == ddsclp_pkg::FLD_PHASE) begin
        r.ps    = s.acc[15:0];
        r.ff[2] = 1'b1;
      end
      r.first = 1'b0;
      r.ph    = ddsclp_pkg::PH_BETWEEN;
    end
    return r;
  endfunction

  function automatic scan_t feed(scan_t s, ddsclp_pkg::byte_cls_t c,
                                 logic [28:0] fl, logic [15:0] al, logic [15:0] pl);
    scan_t       r;
    logic [2:0]  code;
    logic [32:0] v;
    logic [28:0] lim;
    r = s;
    // query tracking runs on every content byte but leading blanks
    if (!(s.qpos == 3'd0 && c.is_blank)) begin
      if (s.qpos >= 3'd4) begin
        r.qflags[0] = 1'b0;
      end else if (ddsclp_pkg::Q_DDS[31 - 8 * s.qpos -: 8] != c.upper) begin
        r.qflags[0] = 1'b0;
      end
      if (s.qpos >= 3'd7) begin
        r.qflags[1] = 1'b0;
      end else if (ddsclp_pkg::Q_SINGLE[55 - 8 * s.qpos -: 8] != c.upper) begin
        r.qflags[1] = 1'b0;
      end
      if (s.qpos < 3'd7) begin
        r.qpos = s.qpos + 3'd1;
      end
    end
    if (r.ph == ddsclp_pkg::PH_BETWEEN) begin
      if (c.is_sep) begin
        return r;
      end
      r.ph     = ddsclp_pkg::PH_KEY;
      r.kflags = '1;
      r.kpos   = 4'd0;
    end
    if (r.ph == ddsclp_pkg::PH_KEY) begin
      if (c.is_sep) begin
        r = end_token(r, 1'b0);
      end else if (c.is_eq) begin
        code = key_code(r);
        if (code == ddsclp_pkg::FLD_FREQ || code == ddsclp_pkg::FLD_AMP ||
            code == ddsclp_pkg::FLD_PHASE) begin
          r.fld = code;
          r.acc = '0;
          r.ph  = ddsclp_pkg::PH_VAL_EMPTY;
        end else begin
          r = set_error(r, ddsclp_pkg::ST_FORMAT);
        end
      end else begin
        for (int i = 0; i < KN; i++) begin
          if (r.kflags[i]) begin
            if (r.kpos >= ddsclp_pkg::KW_LEN[i]) begin
              r.kflags[i] = 1'b0;
            end else if (ddsclp_pkg::KW_TEXT[i][71 - 8 * r.kpos -: 8] != c.upper) begin
              r.kflags[i] = 1'b0;
            end
          end
        end
        if (r.kpos != 4'd15) begin
          r.kpos = r.kpos + 4'd1;
        end
      end
    end else if (r.ph == ddsclp_pkg::PH_VAL_EMPTY || r.ph == ddsclp_pkg::PH_VAL_DIGITS) begin
      if (c.is_sep) begin
        r = end_token(r, 1'b0);
      end else if (c.is_digit) begin
        lim = (r.fld == ddsclp_pkg::FLD_FREQ) ? fl :
              (r.fld == ddsclp_pkg::FLD_AMP) ? {13'd0, al} : {13'd0, pl};
        v = ({4'd0, r.acc} << 3) + ({4'd0, r.acc} << 1) + {29'd0, c.digit};
        if (v > {4'd0, lim}) begin
          r = set_error(r, ddsclp_pkg::ST_RANGE);
        end else begin
          r.acc = v[28:0];
          r.ph  = ddsclp_pkg::PH_VAL_DIGITS;
        end
      end else begin
        r = set_error(r, ddsclp_pkg::ST_FORMAT);
      end
    end
    return r;
  endfunction

  scan_t             s_r, s_nxt, fin;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              back_ready, emit;
  logic [1:0]        est;
  logic              withv;
  logic              query;

  logic              ov_r, ov_nxt;
  logic [1:0]        ost_r;
  logic [28:0]       ofs_r;
  logic [15:0]       oas_r, ops_r;
  logic [2:0]        off_r;

  assign back_ready = !ov_r || out_ready;
  assign pop        = q_valid && back_ready;

  always_comb begin
    s_nxt   = s_r;
    len_nxt = len_r;
    fin     = s_r;
    emit    = 1'b0;
    est     = ddsclp_pkg::ST_OK;
    withv   = 1'b0;
    query   = (s_r.qflags[0] && s_r.qpos == 3'd4) || (s_r.qflags[1] && s_r.qpos == 3'd7);
    if (pop) begin
      if (q_cls.is_eol) begin
        if (len_r != '0) begin
          if (query) begin
            emit = 1'b1;
            est  = ddsclp_pkg::ST_QUERY;
          end else begin
            if (s_r.ph != ddsclp_pkg::PH_BETWEEN && s_r.ph != ddsclp_pkg::PH_SKIP) begin
              fin = end_token(s_r, 1'b1);
            end
            if (fin.err != ddsclp_pkg::ST_OK) begin
              emit = 1'b1;
              est  = fin.err;
            end else if (!fin.first) begin
              emit = 1'b1;
              if (fin.ff == 3'd0) begin
                est = ddsclp_pkg::ST_FORMAT;
              end else begin
                withv = 1'b1;
              end
            end
          end
          s_nxt   = line_init();
          len_nxt = '0;
        end
      end else if (len_r < LEN_W'(LINE_CHARS - 1)) begin
        len_nxt = len_r + 1'b1;
        if (!s_r.ended) begin
          if (q_cls.is_nul) begin
            s_nxt.ended = 1'b1;
          end else begin
            s_nxt = feed(s_r, q_cls, freq_limit, amp_limit, phase_limit);
          end
        end
      end else begin
        // overlong line: report and start over
        s_nxt   = line_init();
        len_nxt = '0;
        emit    = 1'b1;
        est     = ddsclp_pkg::ST_FORMAT;
      end
    end
    ov_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r   <= line_init();
      len_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      s_r   <= s_nxt;
      len_r <= len_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ost_r <= est;
      ofs_r <= withv ? fin.fs : 29'd0;
      oas_r <= withv ? fin.as : 16'd0;
      ops_r <= withv ? fin.ps : 16'd0;
      off_r <= withv ? fin.ff : 3'd0;
    end
  end

  assign out_valid          = ov_r;
  assign out_line_status    = ost_r;
  assign out_frequency_hz   = ofs_r;
  assign out_amplitude_word = oas_r;
  assign out_phase_degrees  = ops_r;
  assign out_fields_given   = off_r;

`ifndef SYNTHESIS
  a_err_no_values: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ost_r != ddsclp_pkg::ST_OK |-> off_r == 3'd0 && ofs_r == 29'd0)
    else $error("error result carries values");
  a_ok_has_field: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ost_r == ddsclp_pkg::ST_OK |-> off_r != 3'd0)
    else $error("settings result without fields");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |-> !pop)
    else $error("beat taken while result stalled");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_CHARS - 1))
    else $error("line length past limit");
`endif

endmodule
`default_nettype wire

// ----- hdl/dds_command_line_parser.sv -----
// Top level of the DDS command line parser.
//
// Bytes enter on in_* one beat per cycle; CR or LF closes a line and a result
// beat (status, frequency, amplitude, phase, field mask) leaves on out_* for
// every line that held more than separators before any NUL. Keys match without
// regard to case. Sustained rate is one byte per cycle: the back-end scanner
// retires one byte per clock, and a two-beat queue between classifier and
// scanner plus the result register absorb two input beats while a result
// waits; after that in_ready drops until the result is taken. Limits are to be
// written through cfg_* only while no beat is in flight, which the user must
// keep to as the block itself does not enforce it; index 0 frequency,
// 1 amplitude, 2 phase, other indexes are ignored.
`default_nettype none
module dds_command_line_parser #(
  parameter int LINE_CHARS = 80
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_line_status,
  output logic [28:0]      out_frequency_hz,
  output logic [15:0]      out_amplitude_word,
  output logic [15:0]      out_phase_degrees,
  output logic [2:0]       out_fields_given,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_wdata
);

  ddsclp_pkg::byte_cls_t push_cls, q_cls;
  logic push, q_ready, q_valid, pop;

  // limit registers
  logic [28:0] freq_limit_r;
  logic [15:0] amp_limit_r, phase_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_limit_r  <= ddsclp_pkg::FREQ_LIMIT_RST;
      amp_limit_r   <= ddsclp_pkg::AMP_LIMIT_RST;
      phase_limit_r <= ddsclp_pkg::PHASE_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == ddsclp_pkg::REG_FREQ_LIMIT) begin
        freq_limit_r <= cfg_wdata;
      end
      if (cfg_index == ddsclp_pkg::REG_AMP_LIMIT) begin
        amp_limit_r <= cfg_wdata[15:0];
      end
      if (cfg_index == ddsclp_pkg::REG_PHASE_LIMIT) begin
        phase_limit_r <= cfg_wdata[15:0];
      end
    end
  end

  // classify incoming bytes
  ddsclp_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .push_cls   (push_cls),
    .q_ready    (q_ready)
  );

  // decouples classifier from scanner
  ddsclp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cls (push_cls),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_cls    (q_cls),
    .pop      (pop)
  );

  // scanner, parser and result register
  ddsclp_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_cls              (q_cls),
    .pop                (pop),
    .freq_limit         (freq_limit_r),
    .amp_limit          (amp_limit_r),
    .phase_limit        (phase_limit_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_status    (out_line_status),
    .out_frequency_hz   (out_frequency_hz),
    .out_amplitude_word (out_amplitude_word),
    .out_phase_degrees  (out_phase_degrees),
    .out_fields_given   (out_fields_given)
  );

endmodule
`default_nettype wire

// ----- verif/dds_command_line_parser_tb.sv -----
// Self-checking testbench for the DDS command line parser: byte lines in, checked results out.
`timescale 1ns / 100ps

module dds_command_line_parser_tb;

  localparam int LINE_MAX = 80;
  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [28:0] freq;
    logic [15:0] amp;
    logic [15:0] phase;
    logic [2:0]  flags;
  } line_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_line_status;
  logic [28:0] out_frequency_hz;
  logic [15:0] out_amplitude_word;
  logic [15:0] out_phase_degrees;
  logic [2:0]  out_fields_given;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = ddsclp_pkg::REG_FREQ_LIMIT;
  logic [28:0] cfg_wdata = 29'd0;

  always #1 clk = ~clk;

  dds_command_line_parser u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_line_status(out_line_status), .out_frequency_hz(out_frequency_hz),
    .out_amplitude_word(out_amplitude_word), .out_phase_degrees(out_phase_degrees),
    .out_fields_given(out_fields_given),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // pending bytes for the driver, expected line results for the monitor
  logic [7:0] tx_bytes[$];
  line_res_t  line_results[$];

  int errors = 0;
  int bytes_sent = 0;
  int lines_checked = 0;
  int send_idle = 0;   // percent of cycles the sender holds off
  int recv_stall = 0;  // percent of cycles the receiver holds off
  bit long_hold_req = 0;

  // ---------------------------------------------------------------------------
  // Line parser prediction: own copy of limits and per-line scan state
  // ---------------------------------------------------------------------------
  logic [28:0] lim_freq;
  logic [15:0] lim_amp, lim_phase;

  int         n_chars;
  logic [2:0] scan_ph;
  bit         first_tok;
  logic [15:0] kw_live;
  int         kw_pos;
  logic [1:0] q_live;
  int         q_pos;
  logic [31:0] acc;
  logic [2:0] cur_fld;
  logic [1:0] err_code;
  bit         nul_seen;
  logic [31:0] freq_val;
  logic [15:0] amp_val, phase_val;
  logic [2:0] got_mask;

  task automatic clear_line();
    n_chars = 0; scan_ph = ddsclp_pkg::PH_BETWEEN; first_tok = 1;
    kw_live = 16'hFFFF; kw_pos = 0;
    q_live = 2'b11; q_pos = 0; acc = 0; cur_fld = ddsclp_pkg::FLD_NONE;
    err_code = ddsclp_pkg::ST_OK;
    nul_seen = 0; freq_val = 0; amp_val = 0; phase_val = 0; got_mask = 0;
  endtask

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic bit is_sep(logic [7:0] c);
    return c == " " || c == 8'h09 || c == ",";
  endfunction

  // field code of the keyword matched so far, FLD_NONE if none
  function automatic logic [2:0] matched_key();
    for (int i = 0; i < ddsclp_pkg::KW_COUNT; i++)
      if (kw_live[i] && ddsclp_pkg::KW_LEN[i] == kw_pos) return ddsclp_pkg::KW_CODE[i];
    return ddsclp_pkg::FLD_NONE;
  endfunction

  task automatic flag_error(logic [1:0] code);
    if (err_code == ddsclp_pkg::ST_OK) err_code = code;
    scan_ph = ddsclp_pkg::PH_SKIP;
  endtask

  task automatic close_token(bit at_end);
    if (scan_ph == ddsclp_pkg::PH_KEY) begin
      if (!at_end && first_tok && matched_key() == ddsclp_pkg::FLD_PREFIX) begin
        first_tok = 0;
        scan_ph = ddsclp_pkg::PH_BETWEEN;
      end else flag_error(ddsclp_pkg::ST_FORMAT);
    end else if (scan_ph == ddsclp_pkg::PH_VAL_EMPTY) begin
      flag_error(ddsclp_pkg::ST_FORMAT);
    end else if (scan_ph == ddsclp_pkg::PH_VAL_DIGITS) begin
      case (cur_fld)
        ddsclp_pkg::FLD_FREQ:  begin freq_val = acc; got_mask[0] = 1; end
        ddsclp_pkg::FLD_AMP:   begin amp_val = acc[15:0]; got_mask[1] = 1; end
        ddsclp_pkg::FLD_PHASE: begin phase_val = acc[15:0]; got_mask[2] = 1; end
        default: ;
      endcase
      first_tok = 0;
      scan_ph = ddsclp_pkg::PH_BETWEEN;
    end
  endtask

  task automatic scan_char(logic [7:0] c);
    logic [7:0] u;
    logic [2:0] code;
    logic [63:0] v;
    logic [31:0] lim;
    u = upcase(c);
    // query tracking ignores leading blanks (not commas)
    if (!(q_pos == 0 && (c == " " || c == 8'h09))) begin
      if (q_pos >= 4 || ddsclp_pkg::Q_DDS[31 - 8*q_pos -: 8] != u) q_live[0] = 0;
      if (q_pos >= 7 || ddsclp_pkg::Q_SINGLE[55 - 8*q_pos -: 8] != u) q_live[1] = 0;
      if (q_pos < 7) q_pos++;
    end
    if (scan_ph == ddsclp_pkg::PH_BETWEEN) begin
      if (is_sep(c)) return;
      scan_ph = ddsclp_pkg::PH_KEY;
      kw_live = 16'hFFFF;
      kw_pos = 0;
    end
    if (scan_ph == ddsclp_pkg::PH_KEY) begin
      if (is_sep(c)) close_token(0);
      else if (c == "=") begin
        code = matched_key();
        if (code == ddsclp_pkg::FLD_FREQ || code == ddsclp_pkg::FLD_AMP ||
            code == ddsclp_pkg::FLD_PHASE) begin
          cur_fld = code;
          acc = 0;
          scan_ph = ddsclp_pkg::PH_VAL_EMPTY;
        end else flag_error(ddsclp_pkg::ST_FORMAT);
      end else begin
        for (int i = 0; i < ddsclp_pkg::KW_COUNT; i++)
          if (kw_live[i] && (kw_pos >= ddsclp_pkg::KW_LEN[i] ||
                             ddsclp_pkg::KW_TEXT[i][71 - 8*kw_pos -: 8] != u))
            kw_live[i] = 0;
        if (kw_pos < 15) kw_pos++;
      end
    end else if (scan_ph == ddsclp_pkg::PH_VAL_EMPTY ||
                 scan_ph == ddsclp_pkg::PH_VAL_DIGITS) begin
      if (is_sep(c)) close_token(0);
      else if (c >= "0" && c <= "9") begin
        lim = cur_fld == ddsclp_pkg::FLD_FREQ ? {3'd0, lim_freq} :
              cur_fld == ddsclp_pkg::FLD_AMP ? {16'd0, lim_amp} : {16'd0, lim_phase};
        v = 64'(acc) * 10 + 64'(c - "0");
        if (v > 64'(lim)) flag_error(ddsclp_pkg::ST_RANGE);
        else begin
          acc = v[31:0];
          scan_ph = ddsclp_pkg::PH_VAL_DIGITS;
        end
      end else flag_error(ddsclp_pkg::ST_FORMAT);
    end
  endtask

  task automatic push_result(logic [1:0] st, bit with_vals);
    line_res_t r;
    r.status = st;
    r.freq   = with_vals ? freq_val[28:0] : '0;
    r.amp    = with_vals ? amp_val : '0;
    r.phase  = with_vals ? phase_val : '0;
    r.flags  = with_vals ? got_mask : '0;
    line_results.push_back(r);
  endtask

  // one accepted byte: update scan state, queue the line result if one is due
  task automatic take_char(logic [7:0] c);
    if (c == 8'h0D || c == 8'h0A) begin
      if (n_chars == 0) return;
      if ((q_live[0] && q_pos == 4) || (q_live[1] && q_pos == 7))
        push_result(ddsclp_pkg::ST_QUERY, 0);
      else begin
        if (scan_ph != ddsclp_pkg::PH_BETWEEN && scan_ph != ddsclp_pkg::PH_SKIP)
          close_token(1);
        if (err_code != ddsclp_pkg::ST_OK) push_result(err_code, 0);
        else if (!first_tok)
          push_result(got_mask == 0 ? ddsclp_pkg::ST_FORMAT : ddsclp_pkg::ST_OK,
                      got_mask != 0);
      end
      clear_line();
      return;
    end
    if (n_chars < LINE_MAX - 1) begin
      n_chars++;
      if (nul_seen) return;
      if (c == 8'h00) begin
        nul_seen = 1;
        return;
      end
      scan_char(c);
      return;
    end
    // overflow: byte dropped, line restarts
    clear_line();
    push_result(ddsclp_pkg::ST_FORMAT, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one beat per accepted byte, random sender gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_char(in_rx_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid   <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest expected line result
  // ---------------------------------------------------------------------------
  int hold_cnt = 0;

  always @(posedge clk) begin
    line_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (line_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d", $time, out_line_status);
        errors++;
      end else begin
        e = line_results.pop_front();
        lines_checked++;
        if (out_line_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_line_status);
          errors++;
        end
        if (out_frequency_hz !== e.freq) begin
          $display("%0t: frequency exp %0d got %0d", $time, e.freq, out_frequency_hz);
          errors++;
        end
        if (out_amplitude_word !== e.amp) begin
          $display("%0t: amplitude exp %0d got %0d", $time, e.amp, out_amplitude_word);
          errors++;
        end
        if (out_phase_degrees !== e.phase) begin
          $display("%0t: phase exp %0d got %0d", $time, e.phase, out_phase_degrees);
          errors++;
        end
        if (out_fields_given !== e.flags) begin
          $display("%0t: fields exp %0b got %0b", $time, e.flags, out_fields_given);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the input side backs up
  always @(posedge clk) begin
    if (long_hold_req && hold_cnt == 0) begin
      hold_cnt = 250;
      long_hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_stall;
    end
  end

  // watchdog on cycles with no beat on either channel
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, line_results.size());
      $display("dds_command_line_parser_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  function automatic string mixcase(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(1)) r[i] = r[i] + 8'd32;
    return r;
  endfunction

  function automatic string pick_sep();
    case ($urandom_range(4))
      0: return "\t";
      1: return ",";
      2: return " ,";
      default: return " ";
    endcase
  endfunction

  function automatic string pick_eol();
    return $urandom_range(1) ? "\r" : "\n";
  endfunction

  // decimal value around a limit: in range, at it, just past it, or far off
  function automatic string pick_value(logic [31:0] lim);
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = lim;
      2: v = 64'(lim) + 1;
      3: v = 64'($urandom) * 10 + $urandom_range(9);
      default: v = $urandom_range(lim);
    endcase
    return $sformatf("%0d", v);
  endfunction

  task automatic rand_line();
    string s, tok;
    int k, ntok;
    s = "";
    k = $urandom_range(99);
    if (k < 70) begin
      // well-formed setting line with random content, sometimes damaged
      if ($urandom_range(2) == 0) s = {" ", s};
      if ($urandom_range(1)) begin
        case ($urandom_range(2))
          0: s = {s, mixcase("DDS")};
          1: s = {s, mixcase("SINGLE")};
          default: s = {s, mixcase("S")};
        endcase
        s = {s, pick_sep()};
      end
      ntok = $urandom_range(4, 1);
      for (int t = 0; t < ntok; t++) begin
        case ($urandom_range(9))
          0: tok = {mixcase("F"), "=", pick_value(lim_freq)};
          1: tok = {mixcase("FREQ"), "=", pick_value(lim_freq)};
          2: tok = {mixcase("FREQUENCY"), "=", pick_value(lim_freq)};
          3: tok = {mixcase("A"), "=", pick_value(lim_amp)};
          4: tok = {mixcase("AMP"), "=", pick_value(lim_amp)};
          5: tok = {mixcase("AMPLITUDE"), "=", pick_value(lim_amp)};
          6: tok = {mixcase("P"), "=", pick_value(lim_phase)};
          7: tok = {mixcase("PH"), "=", pick_value(lim_phase)};
          8: tok = {mixcase("PHA"), "=", pick_value(lim_phase)};
          default: tok = {mixcase("PHASE"), "=", pick_value(lim_phase)};
        endcase
        if ($urandom_range(11) == 0) tok[$urandom_range(tok.len() - 1)] = 8'($urandom);
        s = {s, tok, (t < ntok - 1 || $urandom_range(3) == 0) ? pick_sep() : ""};
      end
    end else if (k < 78) begin
      // query, sometimes with a stray trailing byte
      s = $urandom_range(1) ? mixcase("DDS?") : mixcase("SINGLE?");
      if ($urandom_range(1)) s = {"\t ", s};
      if ($urandom_range(3) == 0) s = {s, "x"};
    end else if (k < 87) begin
      // raw noise, any byte value
      for (int i = 0; i < $urandom_range(12, 1); i++) s = {s, " "};
      for (int i = 0; i < s.len(); i++) s[i] = 8'($urandom);
    end else if (k < 91) begin
      // runs near or past the line length limit
      for (int i = 0; i < $urandom_range(95, 78); i++) s = {s, "a"};
    end else if (k < 95) begin
      s = $urandom_range(1) ? "" : " \t,";
    end else begin
      // NUL ends the content, the tail is ignored; strings cannot hold NUL
      s = {mixcase("F"), "=12", " ", "A=zz"};
      k = $urandom_range(s.len() - 1);
      for (int i = 0; i < s.len(); i++) tx_bytes.push_back(i == k ? 8'h00 : s[i]);
      s = "";
    end
    send_str({s, pick_eol()});
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() > 0 || in_valid || line_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [28:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      ddsclp_pkg::REG_FREQ_LIMIT:  lim_freq = val;
      ddsclp_pkg::REG_AMP_LIMIT:   lim_amp = val[15:0];
      ddsclp_pkg::REG_PHASE_LIMIT: lim_phase = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    lim_freq = ddsclp_pkg::FREQ_LIMIT_RST;
    lim_amp = ddsclp_pkg::AMP_LIMIT_RST;
    lim_phase = ddsclp_pkg::PHASE_LIMIT_RST;
    clear_line();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines at reset limits
    send_str("F=420000000\r");
    send_str("dds freq=0,Amp=16383\tph=360\n");
    send_str("FREQUENCY=420000001\r");
    send_str("single AMPLITUDE=16384 p=1\r");
    send_str("PHASE=361\n");
    send_str("pha=12\r");
    send_str("  DDS?\r");
    send_str("\tsingle?\n");
    send_str("DDS? \r");
    send_str("S\r");
    send_str("s a=5 dds\r");
    send_str("X=5\r");
    send_str("A=\r");
    send_str("P=1x\r");
    send_str("F=7,F=8\r");
    send_str("\r\n");
    send_str(" \t,\r");
    tx_bytes.push_back(8'h00);
    send_str("F=1\r");
    send_str("A=2");
    tx_bytes.push_back(8'h00);
    send_str("zz\r");
    send_str({"amp=3", 8'hFF, "\r"});
    for (int i = 0; i < 82; i++) send_str("9");
    send_str("\r");
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 50; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 50; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      // limits for this phase, idle block only
      case (ph)
        1: begin
          write_reg(ddsclp_pkg::REG_FREQ_LIMIT, 29'h1FFFFFFF);
          write_reg(ddsclp_pkg::REG_AMP_LIMIT, 29'hFFFF);
          write_reg(ddsclp_pkg::REG_PHASE_LIMIT, 29'hFFFF);
        end
        2: begin
          write_reg(ddsclp_pkg::REG_FREQ_LIMIT, 29'd0);
          write_reg(ddsclp_pkg::REG_AMP_LIMIT, 29'd0);
          write_reg(ddsclp_pkg::REG_PHASE_LIMIT, 29'd0);
          write_reg(2'd3, 29'h1555);
        end
        3: begin
          write_reg(ddsclp_pkg::REG_FREQ_LIMIT, 29'($urandom));
          write_reg(ddsclp_pkg::REG_AMP_LIMIT, 29'($urandom_range(65535)));
          write_reg(ddsclp_pkg::REG_PHASE_LIMIT, 29'($urandom_range(1000)));
        end
        default: ;
      endcase
      if (ph == 0) long_hold_req = 1;
      while (tx_bytes.size() < 290) rand_line();
      wait_idle();
    end

    $display("Sent %0d bytes over four flow-control phases and four limit settings;",
             bytes_sent);
    $display("%0d line results checked (settings, queries, format/range errors).",
             lines_checked);
    if (errors == 0) begin
      $display("dds_command_line_parser_tb: clean");
    end else begin
      $display("dds_command_line_parser_tb: errors");
    end
    $finish;
  end

endmodule
